// ----- hw/rtl/vsd_pkg.sv -----
// shared widths, register indexes and reset values for the speech detector
`timescale 1ns / 1ps

package vsd_pkg;

    // fixed field widths
    localparam int SAMPLE_W    = 16;
    localparam int SQUARE_W    = 31;
    localparam int SUM_W       = 41;
    localparam int LEVEL_W     = 28;
    localparam int REG_THR_W   = 21;
    localparam int DEBOUNCE_W  = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 21;
    localparam int M_TDATA_W   = 32;

    // default fraction bits of the energy result
    localparam int DEFAULT_ENERGY_FRAC_BITS = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_DB   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DB  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_THR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_THR = 3'd4;

    // register reset values
    localparam logic                  RST_ENABLE  = 1'b1;
    localparam logic [DEBOUNCE_W-1:0] RST_ON_DB   = 8'd3;
    localparam logic [DEBOUNCE_W-1:0] RST_OFF_DB  = 8'd20;
    localparam logic [REG_THR_W-1:0]  RST_MIN_THR = 21'd3000;
    localparam logic [REG_THR_W-1:0]  RST_MAX_THR = 21'd10000;

    // result of the root unit
    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] root;
    } t_root_res;

endpackage

// ----- hw/rtl/vsd_sqrt.sv -----
// bit-serial square root of the block sum, one result bit per cycle
`timescale 1ns / 1ps

module vsd_sqrt #(
    parameter int ENERGY_FRAC_BITS = vsd_pkg::DEFAULT_ENERGY_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [vsd_pkg::SUM_W-1:0] i_sum,
    output vsd_pkg::t_root_res       o_res
);
    import vsd_pkg::*;

    localparam int X_W       = 2 * LEVEL_W;
    localparam int REM_W     = LEVEL_W + 2;
    localparam int CNT_W     = $clog2(LEVEL_W);
    localparam int SAT_SHIFT = X_W - 2 * ENERGY_FRAC_BITS;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [X_W-1:0]     r_x;
    logic [REM_W-1:0]   r_rem;
    logic [LEVEL_W-1:0] r_root;

    logic               w_sat;
    logic [X_W-1:0]     w_x;
    logic [REM_W-1:0]   w_rem_sh;
    logic [REM_W-1:0]   w_trial;
    logic               w_fit;
    logic [REM_W-1:0]   n_rem;
    logic [LEVEL_W-1:0] n_root;

    // root reaches 2^28 exactly when the sum reaches 2^(56-2F)
    assign w_sat = (i_sum >> SAT_SHIFT) != '0;
    assign w_x   = X_W'(i_sum) << (2 * ENERGY_FRAC_BITS);

    // one restoring step: bring down two bits, try root*4+1
    assign w_rem_sh = {r_rem[REM_W-3:0], r_x[X_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fit    = w_rem_sh >= w_trial;
    assign n_rem    = w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
    assign n_root   = {r_root[LEVEL_W-2:0], w_fit};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !w_sat;
                r_done <= w_sat;
                r_cnt  <= CNT_W'(LEVEL_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= w_x;
            r_rem  <= '0;
            r_root <= w_sat ? '1 : '0;
        end else if (r_busy) begin
            r_x    <= {r_x[X_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_res.done = r_done;
    assign o_res.root = r_root;

endmodule

// ----- hw/rtl/vox_speech_detector_core.sv -----
// energy-tracking voice activity detector, top level
//
// Usage:
//  - slave stream: one signed 16-bit sample per item in tdata, tlast marks the
//    last sample of a block; each sample is squared into a saturating 41-bit sum
//  - master stream: one item per block, sent after the block's last sample:
//    debounced voice flag and the block energy sqrt(sum) in unsigned Q20.8
//  - config channel: register index and data, always ready; to be written while idle, which the core does not enforce
//  - an ordinary sample is accepted, then squared and added to the sum;
//    a last sample passes through accumulate, root start, the bit-serial root
//    unit (one result bit per cycle), then the speech tracker, noise tracker,
//    threshold and decision-with-debounce steps and the emit step that loads the output
//  - a sum beyond the root's range skips the bit-serial root steps
//  - when detection is disabled a last sample yields the held flag with zero
//    energy and skips the root and detector steps
//  - s_tready is high only while the sequencer is idle
//  - the result sits in an output register; a stalled receiver holds it there,
//    and the next block's result waits in the sequencer until it is taken
//  - reset restores the register defaults and clears sum, trackers and flags
`timescale 1ns / 1ps

module vox_speech_detector_core #(
    parameter int ENERGY_FRAC_BITS = vsd_pkg::DEFAULT_ENERGY_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [vsd_pkg::SAMPLE_W-1:0]   i_s_tdata,   // [15:0] sample
    input  logic                           i_s_tlast,   // block_last
    // master stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [vsd_pkg::M_TDATA_W-1:0]  o_m_tdata,   // [0] voice_active, [28:1] block_energy
    // configuration write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vsd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vsd_pkg::*;

    localparam int THR_W = (REG_THR_W + ENERGY_FRAC_BITS > LEVEL_W + 1) ?
                           (REG_THR_W + ENERGY_FRAC_BITS) : (LEVEL_W + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ACC    = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_ROOT   = 4'd3;
    localparam logic [3:0] S_SPEECH = 4'd4;
    localparam logic [3:0] S_NOISE  = 4'd5;
    localparam logic [3:0] S_THR    = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0]            r_state;
    logic                  r_enable;
    logic [DEBOUNCE_W-1:0] r_on_db;
    logic [DEBOUNCE_W-1:0] r_off_db;
    logic [REG_THR_W-1:0]  r_min_thr;
    logic [REG_THR_W-1:0]  r_max_thr;
    logic [SQUARE_W-1:0]   r_square;
    logic                  r_last;
    logic [SUM_W-1:0]      r_sum;
    logic [LEVEL_W-1:0]    r_energy;
    logic [LEVEL_W-1:0]    r_speech;
    logic [LEVEL_W-1:0]    r_noise;
    logic [THR_W-1:0]      r_thr;
    logic                  r_raw;
    logic                  r_held;
    logic [DEBOUNCE_W-1:0] r_db_cnt;
    logic                  r_m_valid;
    logic                  r_m_voice;
    logic [LEVEL_W-1:0]    r_m_energy;

    logic                  w_s_acc;
    logic                  w_m_free;
    logic [2*SAMPLE_W-1:0] w_product;
    logic [SUM_W:0]        w_sum_wide;
    logic [SUM_W-1:0]      n_sum;
    t_root_res             w_root;

    logic                  w_is_noise;
    logic [LEVEL_W-1:0]    w_level;
    logic                  w_ge;
    logic [LEVEL_W:0]      w_diff;
    logic [LEVEL_W:0]      w_up_step;
    logic [LEVEL_W:0]      w_dn_step;
    logic [LEVEL_W-1:0]    n_level;

    logic [THR_W-1:0]      w_lo;
    logic [THR_W-1:0]      w_hi;
    logic [THR_W-1:0]      w_quiet_a;
    logic [THR_W-1:0]      w_quiet_b;
    logic [THR_W-1:0]      w_quiet;
    logic [THR_W-1:0]      w_base;
    logic [THR_W-1:0]      n_thr;

    logic                  w_det;
    logic [LEVEL_W+1:0]    w_noise3;
    logic [DEBOUNCE_W-1:0] w_limit;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_m_free    = !r_m_valid || i_m_tready;

    // square and saturating accumulate
    assign w_product  = $signed(i_s_tdata) * $signed(i_s_tdata);
    assign w_sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(r_square);
    assign n_sum      = w_sum_wide[SUM_W] ? '1 : w_sum_wide[SUM_W-1:0];

    // shared tracker step: speech rises by 1/4 and falls by 1/64, noise the reverse
    assign w_is_noise = (r_state == S_NOISE);
    assign w_level    = w_is_noise ? r_noise : r_speech;
    assign w_ge       = r_energy >= w_level;
    assign w_diff     = w_ge ? ({1'b0, r_energy} - {1'b0, w_level})
                             : ({1'b0, w_level} - {1'b0, r_energy});
    assign w_up_step  = w_is_noise ? (w_diff >> 6) : (w_diff >> 2);
    assign w_dn_step  = w_is_noise ? ((w_diff + (LEVEL_W + 1)'(3)) >> 2)
                                   : ((w_diff + (LEVEL_W + 1)'(63)) >> 6);
    assign n_level    = w_ge ? LEVEL_W'({1'b0, w_level} + w_up_step)
                             : LEVEL_W'({1'b0, w_level} - w_dn_step);

    // threshold: speech/8 while speaking, else max(speech/16, 2*noise) capped at the max; both floored at the min
    assign w_lo      = THR_W'(r_min_thr) << ENERGY_FRAC_BITS;
    assign w_hi      = THR_W'(r_max_thr) << ENERGY_FRAC_BITS;
    assign w_quiet_a = THR_W'(r_speech >> 4);
    assign w_quiet_b = THR_W'({r_noise, 1'b0});
    assign w_quiet   = (w_quiet_a > w_quiet_b) ? w_quiet_a : w_quiet_b;
    assign w_base    = r_raw ? THR_W'(r_speech >> 3)
                             : ((w_quiet > w_hi) ? w_hi : w_quiet);
    assign n_thr     = (w_base < w_lo) ? w_lo : w_base;

    // decision and noise scaling by three quarters
    assign w_det    = THR_W'(r_energy) > r_thr;
    assign w_noise3 = {2'b00, r_noise} + {1'b0, r_noise, 1'b0};
    assign w_limit  = r_held ? r_off_db : r_on_db;

    vsd_sqrt #(
        .ENERGY_FRAC_BITS (ENERGY_FRAC_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_sum   (r_sum),
        .o_res   (w_root)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= RST_ENABLE;
            r_on_db   <= RST_ON_DB;
            r_off_db  <= RST_OFF_DB;
            r_min_thr <= RST_MIN_THR;
            r_max_thr <= RST_MAX_THR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ENABLE:  r_enable  <= i_cfg_data[0];
                REG_ON_DB:   r_on_db   <= i_cfg_data[DEBOUNCE_W-1:0];
                REG_OFF_DB:  r_off_db  <= i_cfg_data[DEBOUNCE_W-1:0];
                REG_MIN_THR: r_min_thr <= i_cfg_data[REG_THR_W-1:0];
                REG_MAX_THR: r_max_thr <= i_cfg_data[REG_THR_W-1:0];
                default: ;
            endcase
        end
    end

    // item payload held for the accumulate step
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_square <= w_product[SQUARE_W-1:0];
            r_last   <= i_s_tlast;
        end
    end

    // sequencer and detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sum    <= '0;
            r_speech <= '0;
            r_noise  <= '0;
            r_raw    <= 1'b0;
            r_held   <= 1'b0;
            r_db_cnt <= '0;
            r_energy <= '0;
            r_thr    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (!r_enable) begin
                        r_sum    <= '0;
                        r_energy <= '0;
                        r_state  <= r_last ? S_EMIT : S_IDLE;
                    end else begin
                        r_sum   <= n_sum;
                        r_state <= r_last ? S_START : S_IDLE;
                    end
                end
                S_START: begin
                    r_sum   <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (w_root.done) begin
                        r_energy <= w_root.root;
                        r_state  <= S_SPEECH;
                    end
                end
                S_SPEECH: begin
                    r_speech <= n_level;
                    r_state  <= S_NOISE;
                end
                S_NOISE: begin
                    r_noise <= n_level;
                    r_state <= S_THR;
                end
                S_THR: begin
                    r_thr   <= n_thr;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (w_det && r_raw) begin
                        r_noise <= w_noise3[LEVEL_W+1:2];
                    end
                    r_raw <= w_det;
                    // debounce against the new raw bit
                    if (r_held != w_det) begin
                        if (r_db_cnt >= w_limit) begin
                            r_held   <= w_det;
                            r_db_cnt <= '0;
                        end else if (r_db_cnt != '1) begin
                            r_db_cnt <= r_db_cnt + 1'b1;
                        end
                    end else begin
                        r_db_cnt <= '0;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_m_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_m_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_m_free) begin
            r_m_voice  <= r_held;
            r_m_energy <= r_energy;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(M_TDATA_W - LEVEL_W - 1){1'b0}}, r_m_energy, r_m_voice};

    // the root unit reports only while the sequencer waits for it
    a_root_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root.done |-> (r_state == S_ROOT))
        else $error("root result outside the root step");

    // agreement between raw and held bits always leaves the count clear
    a_db_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_raw == r_held) |-> (r_db_cnt == '0))
        else $error("debounce count set while raw and held agree");

    // a new result only comes from the emit step
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(o_m_tvalid)) |-> ($past(r_state) == S_EMIT))
        else $error("result appeared without the emit step");

endmodule
